// ----- rtl/core/rsd_pkg.sv -----
// Package for the run-length sprite decoder: payload structs, decode phase
// codes, configuration register indexes and fixed widths.
// No dependencies.
`default_nettype none

package rsd_pkg;

    localparam int COORD_W    = 11;
    localparam int USED_W     = 9;
    localparam int POS_W      = 21;
    localparam int ADDR_W     = 20;
    localparam int BYTE_W     = 8;
    localparam int COLOR_W    = 24;
    localparam int PIXEL_W    = 32;
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_IDX_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [USED_W-1:0]  USED_MAX  = '1;
    localparam logic [POS_W-1:0]   POS_MAX   = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_OUTPUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MASK     = 3'd4;

    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_DATA    = 1'b1;

    typedef enum logic [3:0] {
        PH_ROWCOUNT = 4'b0001,
        PH_SKIP     = 4'b0010,
        PH_SOLID    = 4'b0100,
        PH_PIXEL    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic                 command;
        logic [PAL_IDX_W-1:0] palette_index;
        logic [COLOR_W-1:0]   palette_color;
        logic [BYTE_W-1:0]    data_byte;
    } t_in_item;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] pixel_address;
        logic [PIXEL_W-1:0] pixel_color;
        logic              image_done;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/core/rle_sprite_decoder_unit.sv -----
// Run-length sprite decoder top level: decode state, palette RAM, address
// and colour stage, output register. Depends on rsd_pkg and rsd_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries palette writes
//   (command 0) and encoded sprite bytes (command 1). Output channel
//   (o_out_valid / i_out_stall / o_out) carries one transaction for each
//   byte that writes a pixel or finishes the image.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
//   the user must use it only while the decoder is idle (not enforced here).
//   Throughput: one input transaction per cycle, sustained while the output
//   is not stalled. The decode state is updated in the accept cycle while the
//   palette RAM is read; the address multiply and colour merge follow in the middle stage.
//   Path: each result goes through the middle stage, then the output register.
//   Stall: when the receiver stalls, the output register holds its
//   transaction, one more result waits in the middle stage, and o_in_stall
//   rises only when both are occupied.
//   Reset: synchronous, active low; clears the decode state and pipeline
//   valids and sets the configuration registers to their reset values. The
//   palette is not cleared and must be written before use.
`default_nettype none

module rle_sprite_decoder_unit
    import rsd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic [POS_W-1:0]   r_plen;
    logic               r_rotate;
    logic [PIXEL_W-1:0] r_alpha;

    // decode state
    t_phase             r_phase, n_phase;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [BYTE_W-1:0]  r_total, n_total;
    logic [USED_W-1:0]  r_used, n_used;
    logic [BYTE_W-1:0]  r_run, n_run;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_fin, n_fin;

    // middle stage and output register
    logic               r_s1_valid;
    logic               r_s1_wrote;
    logic               r_s1_done;
    logic [COORD_W-1:0] r_s1_row;
    logic [COORD_W-1:0] r_s1_col;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               out_free;
    logic               s1_free;
    logic               accept;
    logic               data_acc;
    logic               pal_acc;
    logic               wrote;
    logic               emit;
    logic [COLOR_W-1:0] pal_rd_data;

    logic [BYTE_W-1:0]  b;
    logic [COORD_W-1:0] row_inc;
    logic [COORD_W-1:0] row_inc2;
    logic [COORD_W-1:0] col_inc;
    logic [COORD_W:0]   col_sum;
    logic [COORD_W-1:0] skip_col;
    logic [USED_W-1:0]  used_inc;
    logic [POS_W:0]     pos_p1;
    logic [POS_W:0]     pos_p2;
    logic [POS_W:0]     plen_ext;

    logic [COORD_W-1:0]   mul_a;
    logic [COORD_W-1:0]   mul_b;
    logic [2*COORD_W-1:0] prod;
    logic [COORD_W-1:0]   addend;
    t_out_item            s1_item;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;
    assign data_acc   = accept && (i_in.command == CMD_DATA);
    assign pal_acc    = accept && (i_in.command == CMD_PALETTE);

    rsd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (pal_acc),
        .i_wr_addr (i_in.palette_index),
        .i_wr_data (i_in.palette_color),
        .i_rd_en   (data_acc),
        .i_rd_addr (i_in.data_byte),
        .o_rd_data (pal_rd_data)
    );

    // saturating helpers for the decode step
    always_comb begin
        b        = i_in.data_byte;
        row_inc  = (r_row == COORD_MAX) ? r_row : r_row + COORD_W'(1);
        row_inc2 = (row_inc == COORD_MAX) ? row_inc : row_inc + COORD_W'(1);
        col_inc  = (r_col == COORD_MAX) ? r_col : r_col + COORD_W'(1);
        col_sum  = {1'b0, r_col} + (COORD_W+1)'(b);
        skip_col = col_sum[COORD_W] ? COORD_MAX : col_sum[COORD_W-1:0];
        used_inc = (r_used == USED_MAX) ? r_used : r_used + USED_W'(1);
        pos_p1   = {1'b0, r_pos} + (POS_W+1)'(1);
        pos_p2   = {1'b0, r_pos} + (POS_W+1)'(2);
        plen_ext = {1'b0, r_plen};
    end

    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_total = r_total;
        n_used  = r_used;
        n_run   = r_run;
        n_pos   = r_pos;
        n_fin   = r_fin;
        wrote   = 1'b0;
        emit    = 1'b0;
        if (data_acc) begin
            if (r_fin || r_row >= r_height) begin
                n_fin = 1'b1;
            end else begin
                n_pos = (r_pos == POS_MAX) ? r_pos : pos_p1[POS_W-1:0];
                unique case (r_phase)
                    PH_ROWCOUNT: begin
                        n_total = b;
                        n_used  = USED_W'(1);
                        if (b != '0) begin
                            n_col   = '0;
                            n_phase = PH_SKIP;
                        end else begin
                            n_row   = row_inc;
                            n_fin   = (row_inc >= r_height);
                            n_phase = PH_ROWCOUNT;
                        end
                    end
                    PH_SKIP: begin
                        n_col = skip_col;
                        if (skip_col >= r_width) begin
                            // skip ends the row and is reused as the next count
                            if (pos_p1 >= plen_ext) begin
                                n_fin = 1'b1;
                            end else begin
                                n_row   = row_inc;
                                n_phase = PH_ROWCOUNT;
                                if (row_inc >= r_height) begin
                                    n_fin = 1'b1;
                                end else begin
                                    n_total = b;
                                    n_used  = USED_W'(1);
                                    if (b != '0) begin
                                        n_col   = '0;
                                        n_phase = PH_SKIP;
                                    end else begin
                                        n_row = row_inc2;
                                        n_fin = (row_inc2 >= r_height);
                                    end
                                end
                            end
                        end else begin
                            n_used  = used_inc;
                            n_phase = PH_SOLID;
                        end
                    end
                    PH_SOLID: begin
                        n_used = used_inc;
                        n_run  = b;
                        if (b == '0) begin
                            if (used_inc >= USED_W'(r_total)) begin
                                if (pos_p2 >= plen_ext) begin
                                    n_fin = 1'b1;
                                end else begin
                                    n_row   = row_inc;
                                    n_fin   = (row_inc >= r_height);
                                    n_phase = PH_ROWCOUNT;
                                end
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            n_phase = PH_PIXEL;
                        end
                    end
                    PH_PIXEL: begin
                        wrote  = (r_col < r_width);
                        n_col  = col_inc;
                        n_used = used_inc;
                        n_run  = r_run - BYTE_W'(1);
                        if (r_run == BYTE_W'(1)) begin
                            if (col_inc >= r_width || used_inc >= USED_W'(r_total)) begin
                                if (pos_p2 >= plen_ext) begin
                                    n_fin = 1'b1;
                                end else begin
                                    n_row   = row_inc;
                                    n_fin   = (row_inc >= r_height);
                                    n_phase = PH_ROWCOUNT;
                                end
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_ROWCOUNT;
                    end
                endcase
                emit = wrote || n_fin;
            end
        end
    end

    // address and colour for the transaction in the middle stage
    always_comb begin
        mul_a  = r_rotate ? r_s1_col : r_s1_row;
        mul_b  = r_rotate ? r_height : r_width;
        prod   = (2*COORD_W)'(mul_a) * (2*COORD_W)'(mul_b);
        addend = r_rotate ? (r_height - r_s1_row - COORD_W'(1)) : r_s1_col;
        s1_item.write_valid   = r_s1_wrote;
        s1_item.image_done    = r_s1_done;
        s1_item.pixel_address = '0;
        s1_item.pixel_color   = '0;
        if (r_s1_wrote) begin
            s1_item.pixel_address = prod[ADDR_W-1:0] + ADDR_W'(addend);
            s1_item.pixel_color   = PIXEL_W'(pal_rd_data) | r_alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= COORD_W'(1);
            r_height <= COORD_W'(1);
            r_plen   <= POS_W'(1);
            r_rotate <= 1'b0;
            r_alpha  <= 32'hFF00_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_width  <= i_cfg_data[COORD_W-1:0];
                CFG_IMAGE_HEIGHT:   r_height <= i_cfg_data[COORD_W-1:0];
                CFG_PAYLOAD_LENGTH: r_plen   <= i_cfg_data[POS_W-1:0];
                CFG_ROTATE_OUTPUT:  r_rotate <= i_cfg_data[0];
                CFG_ALPHA_MASK:     r_alpha  <= i_cfg_data[PIXEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ROWCOUNT;
            r_col   <= '0;
            r_row   <= '0;
            r_total <= '0;
            r_used  <= '0;
            r_run   <= '0;
            r_pos   <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_total <= n_total;
            r_used  <= n_used;
            r_run   <= n_run;
            r_pos   <= n_pos;
            r_fin   <= n_fin;
        end
    end

    // middle stage: hold while the output register is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_wrote <= wrote;
            r_s1_done  <= n_fin;
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= s1_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/rsd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds when no read is enabled. No dependencies.
`default_nettype none

module rsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/rle_sprite_decoder_unit_tb.sv -----
// Self-checking testbench for rle_sprite_decoder_unit: palette writes and encoded
// sprite rows go in, and every pixel write and finish transaction is checked.
// Depends on rsd_pkg and the decoder RTL only.
module rle_sprite_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rsd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned LONG_HOLD   = 80;

    class sprite_decode_scoreboard;
        int unsigned        width_reg;
        int unsigned        height_reg;
        int unsigned        length_reg;
        logic               rotate_reg;
        logic [PIXEL_W-1:0] alpha_reg;
        logic [COLOR_W-1:0] palette_rgb [PAL_DEPTH];
        t_phase             phase;
        int unsigned        col, row, row_total, row_used, run_left, byte_pos;
        bit                 done;
        t_out_item          pending_writes [$];
        int unsigned        errors;

        function new();
            width_reg  = 1;
            height_reg = 1;
            length_reg = 1;
            rotate_reg = 1'b0;
            alpha_reg  = 32'hFF00_0000;
            phase      = PH_ROWCOUNT;
            col        = 0;
            row        = 0;
            row_total  = 0;
            row_used   = 0;
            run_left   = 0;
            byte_pos   = 0;
            done       = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:    width_reg  = 32'(data[COORD_W-1:0]);
                CFG_IMAGE_HEIGHT:   height_reg = 32'(data[COORD_W-1:0]);
                CFG_PAYLOAD_LENGTH: length_reg = 32'(data[POS_W-1:0]);
                CFG_ROTATE_OUTPUT:  rotate_reg = data[0];
                CFG_ALPHA_MASK:     alpha_reg  = data;
                default: ;
            endcase
        endfunction

        function int unsigned sat_add(int unsigned a, int unsigned b, int unsigned top);
            int unsigned s;
            s = a + b;
            return (s > top) ? top : s;
        endfunction

        // next_p is the position of the next unread byte
        function void close_row(bit test_end, int unsigned next_p);
            if (test_end && next_p + 1 >= length_reg) begin
                done = 1'b1;
                return;
            end
            row = sat_add(row, 1, 32'(COORD_MAX));
            if (row >= height_reg)
                done = 1'b1;
            phase = PH_ROWCOUNT;
        endfunction

        function void open_row(int unsigned b);
            row_total = b;
            row_used  = 1;
            if (b > 0) begin
                col   = 0;
                phase = PH_SKIP;
            end else begin
                close_row(1'b0, 0);
            end
        endfunction

        function void absorb_item(t_in_item item);
            int unsigned b, pos, addr, h;
            t_out_item   res;
            res = '0;
            if (item.command == CMD_PALETTE) begin
                palette_rgb[item.palette_index] = item.palette_color;
                return;
            end
            if (done || row >= height_reg) begin
                done = 1'b1;
                return;
            end
            b        = 32'(item.data_byte);
            pos      = byte_pos;
            byte_pos = sat_add(pos, 1, 32'(POS_MAX));
            case (phase)
                PH_ROWCOUNT: open_row(b);
                PH_SKIP: begin
                    col = sat_add(col, b, 32'(COORD_MAX));
                    if (col >= width_reg) begin
                        // skip hit the width: close the row, reuse the byte as next count
                        close_row(1'b1, pos);
                        if (!done)
                            open_row(b);
                    end else begin
                        row_used = sat_add(row_used, 1, 32'(USED_MAX));
                        phase    = PH_SOLID;
                    end
                end
                PH_SOLID: begin
                    row_used = sat_add(row_used, 1, 32'(USED_MAX));
                    run_left = b;
                    if (b == 0) begin
                        if (row_used >= row_total)
                            close_row(1'b1, pos + 1);
                        else
                            phase = PH_SKIP;
                    end else begin
                        phase = PH_PIXEL;
                    end
                end
                default: begin
                    if (col < width_reg) begin
                        h = height_reg;
                        if (rotate_reg)
                            addr = (h - row - 1) + col * h;
                        else
                            addr = row * width_reg + col;
                        res.write_valid   = 1'b1;
                        res.pixel_address = addr[ADDR_W-1:0];
                        res.pixel_color   = {8'h00, palette_rgb[item.data_byte]} | alpha_reg;
                    end
                    col      = sat_add(col, 1, 32'(COORD_MAX));
                    row_used = sat_add(row_used, 1, 32'(USED_MAX));
                    run_left = (run_left - 1) & 32'hFF;
                    if (run_left == 0) begin
                        if (col >= width_reg || row_used >= row_total)
                            close_row(1'b1, pos + 1);
                        else
                            phase = PH_SKIP;
                    end
                end
            endcase
            if (res.write_valid || done) begin
                res.image_done = done;
                pending_writes.push_back(res);
            end
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 30)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        endtask

        task check_write(t_out_item got);
            t_out_item want;
            if (pending_writes.size() == 0) begin
                report("unexpected transaction, address", 32'd0, 32'(got.pixel_address));
                return;
            end
            want = pending_writes.pop_front();
            if (got.write_valid !== want.write_valid)
                report("write_valid", 32'(want.write_valid), 32'(got.write_valid));
            if (got.pixel_address !== want.pixel_address)
                report("pixel_address", 32'(want.pixel_address), 32'(got.pixel_address));
            if (got.pixel_color !== want.pixel_color)
                report("pixel_color", want.pixel_color, got.pixel_color);
            if (got.image_done !== want.image_done)
                report("image_done", 32'(want.image_done), 32'(got.image_done));
        endtask

        task flush_leftovers();
            t_out_item want;
            while (pending_writes.size() != 0) begin
                want = pending_writes.pop_front();
                report("missing transaction, address", 32'(want.pixel_address), 32'd0);
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sprite_decode_scoreboard sb;
    int unsigned             burst_left = 0;
    bit                      hold_request = 1'b0;
    int unsigned             cycle_count = 0;

    rle_sprite_decoder_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL rle_sprite_decoder_unit");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_write(out_item);
    end

    // Receiver: stretches of random stall density, plus a long hold on request.
    initial begin : receiver
        int unsigned pct, span;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                case ($urandom_range(0, 3))
                    0: pct = 0;
                    1: pct = 20;
                    2: pct = 50;
                    default: pct = 85;
                endcase
                span = $urandom_range(1, 24);
                repeat (span) begin
                    out_stall <= ($urandom_range(0, 99) < pct);
                    @(posedge clk);
                end
            end
        end
    end

    task automatic push_item(t_in_item item);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.absorb_item(item);
        burst_left--;
    endtask

    task automatic push_data(logic [BYTE_W-1:0] b);
        t_in_item item;
        item.command       = CMD_DATA;
        item.palette_index = PAL_IDX_W'($urandom);
        item.palette_color = COLOR_W'($urandom);
        item.data_byte     = b;
        push_item(item);
    endtask

    task automatic push_palette(logic [PAL_IDX_W-1:0] idx, logic [COLOR_W-1:0] rgb);
        t_in_item item;
        item.command       = CMD_PALETTE;
        item.palette_index = idx;
        item.palette_color = rgb;
        item.data_byte     = BYTE_W'($urandom);
        push_item(item);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(int unsigned w, int unsigned h, int unsigned len, bit rot,
                              logic [PIXEL_W-1:0] alpha);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_PAYLOAD_LENGTH, len);
        write_reg(CFG_ROTATE_OUTPUT, 32'(rot));
        write_reg(CFG_ALPHA_MASK, alpha);
        cfg_we <= 1'b0;
    endtask

    // Hold input until every expected transaction is back, then let the pipe empty.
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_writes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One encoded row: count, then skip / run / index groups. Unclean rows may
    // carry a wrong count or be replaced by raw noise.
    task automatic send_row(bit clean);
        logic [BYTE_W-1:0] row_bytes [$];
        int unsigned       skip, run, w;
        w = sb.width_reg;
        if (!clean && $urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 6)) push_data(BYTE_W'($urandom));
            return;
        end
        row_bytes.push_back(8'd0);
        if ($urandom_range(0, 99) >= 8) begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: skip = $urandom_range(0, 3);
                    5, 6, 7:       skip = $urandom_range(0, w);
                    default:       skip = $urandom_range(0, 255);
                endcase
                if (skip > 255)
                    skip = 255;
                case ($urandom_range(0, 9))
                    0:       run = 0;
                    1, 2:    run = $urandom_range(7, 40);
                    default: run = $urandom_range(1, 6);
                endcase
                if (row_bytes.size() + 2 + run <= 255) begin
                    row_bytes.push_back(BYTE_W'(skip));
                    row_bytes.push_back(BYTE_W'(run));
                    repeat (run) row_bytes.push_back(BYTE_W'($urandom));
                end
            end
            row_bytes[0] = BYTE_W'(row_bytes.size());
            if (!clean && $urandom_range(0, 99) < 10)
                row_bytes[0] = BYTE_W'($urandom_range(0, 255));
        end
        foreach (row_bytes[i]) begin
            if ($urandom_range(0, 99) < 6)
                push_palette(PAL_IDX_W'($urandom), COLOR_W'($urandom));
            push_data(row_bytes[i]);
        end
    endtask

    initial begin : stimulus
        int unsigned       w, h, len, mark, waited;
        bit                rot;
        logic [PIXEL_W-1:0] alpha;
        logic [BYTE_W-1:0] directed [$];
        sb = new();
        // empty row; two pixels; zero run then a skip that spills into the next
        // row's count; writes past the width; a zero run that closes the row
        directed = '{8'd0,
                     8'd5, 8'd0, 8'd2, 8'h00, 8'hFF,
                     8'd8, 8'd1, 8'd0, 8'd0, 8'd1, 8'h80, 8'd5,
                     8'd0, 8'd3, 8'h11, 8'h22, 8'h33,
                     8'd7, 8'd3, 8'd3, 8'h01, 8'h02, 8'h03,
                     8'd3, 8'd0, 8'd0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(4, 1024, 1048576, 1'b0, 32'hFF00_0000);
        // fill the whole palette so no pixel ever reads an unset entry
        for (int i = 0; i < PAL_DEPTH; i++)
            push_palette(PAL_IDX_W'(i), (i == 0) ? 24'h000000 :
                         (i == 255) ? 24'hFFFFFF : COLOR_W'($urandom));
        foreach (directed[i])
            push_data(directed[i]);

        for (int phase_no = 0; phase_no < 8; phase_no++) begin
            settle();
            case (phase_no % 4)
                0: w = 1;
                1: w = 1024;
                2: w = $urandom_range(2, 16);
                default: w = $urandom_range(17, 1024);
            endcase
            if (phase_no % 2 == 0 || sb.row + 300 > 1024)
                h = 1024;
            else
                h = $urandom_range(sb.row + 300, 1024);
            len = (phase_no % 2 == 0) ? 1048576 : $urandom_range(8192, 1048576);
            rot = 1'((phase_no / 4 + phase_no) % 2);
            case (phase_no)
                0: alpha = 32'h0000_0000;
                1: alpha = 32'hFFFF_FFFF;
                2: alpha = 32'hFF00_0000;
                default: alpha = $urandom;
            endcase
            set_config(w, h, len, rot, alpha);
            if (phase_no == 3 || phase_no == 6) begin
                // keep offering while the receiver holds off, so the input stalls
                hold_request = 1'b1;
                burst_left   = 200;
            end
            mark = sb.byte_pos;
            while (sb.byte_pos - mark < 55)
                send_row(1'b0);
        end

        // Align to a row boundary, then end the image with a payload length of
        // one: either the row limit or the early stop ends it.
        settle();
        while (!sb.done && sb.phase != PH_ROWCOUNT)
            push_data(8'd0);
        settle();
        set_config($urandom_range(1, 64), sb.row + 2, 1, 1'($urandom_range(0, 1)), $urandom);
        if ($urandom_range(0, 1))
            push_data(8'd0);
        for (int n = 0; n < 12 && !sb.done; n++)
            send_row(1'b1);
        // decode is over: these produce no transaction
        repeat (10) begin
            if ($urandom_range(0, 1))
                push_palette(PAL_IDX_W'($urandom), COLOR_W'($urandom));
            else
                push_data(BYTE_W'($urandom));
        end

        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending_writes.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        sb.flush_leftovers();
        if (sb.errors == 0)
            $display("PASS rle_sprite_decoder_unit");
        else
            $display("FAIL rle_sprite_decoder_unit");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/rsd_pkg.sv
rtl/core/rsd_ram.sv
rtl/core/rle_sprite_decoder_unit.sv
tb/sv/rle_sprite_decoder_unit_tb.sv
